FILE: design/bfrd_pkg.sv
// Shared types and constants for the box-filter rate decimator.
// Holds the sequencer state type, the divider status bundle and register codes.
// No dependencies.
`default_nettype none

package bfrd_pkg;

  localparam int RATE_W    = 18;
  localparam int CNT_W     = 18;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd2;

  localparam logic [RATE_W-1:0] INPUT_RATE_RST  = 18'd111111;
  localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = 18'd48000;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEFT_GO,
    ST_LEFT_WAIT,
    ST_RIGHT_GO,
    ST_RIGHT_WAIT,
    ST_PUSH
  } bfrd_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bfrd_div_stat_t;

endpackage

`default_nettype wire

FILE: design/bfrd_divider.sv
// Shared iterative signed divider: one quotient bit per cycle.
// Quotient known to fit SAMPLE_BITS bits, so only that many steps are run.
// Depends on bfrd_pkg.
`default_nettype none

module bfrd_divider #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_W       = 35
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SUM_W-1:0]       dividend,
  input  logic [bfrd_pkg::CNT_W-1:0]    divisor,
  output logic signed [SAMPLE_BITS-1:0] quotient,
  output bfrd_pkg::bfrd_div_stat_t      stat
);
  import bfrd_pkg::*;

  localparam int Q      = SAMPLE_BITS;
  localparam int STEP_W = $clog2(Q + 1);

  logic [CNT_W-1:0]  rem_r;
  logic [Q-1:0]      quo_r;
  logic [CNT_W-1:0]  div_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;
  logic              done_r;

  logic              neg_in;
  logic [SUM_W-1:0]  mag_in;
  logic [CNT_W:0]    trial;
  logic [CNT_W+1:0]  diff;
  logic              fits;
  logic [CNT_W-1:0]  rem_nxt;

  assign neg_in = dividend[SUM_W-1];
  assign mag_in = neg_in ? (~dividend + 1'b1) : dividend;

  assign trial   = {rem_r, quo_r[Q-1]};
  assign diff    = {1'b0, trial} - {2'b00, div_r};
  assign fits    = ~diff[CNT_W+1];
  assign rem_nxt = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      step_r <= STEP_W'(Q);
      done_r <= 1'b0;
    end else if (step_r != '0) begin
      step_r <= step_r - 1'b1;
      done_r <= (step_r == STEP_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // The upper dividend bits are already below the divisor, so start there.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= mag_in[Q +: CNT_W];
      quo_r <= mag_in[Q-1:0];
      div_r <= divisor;
      neg_r <= neg_in;
    end else if (step_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[Q-2:0], fits};
    end
  end

  assign quotient  = neg_r ? $signed(~quo_r + 1'b1) : $signed(quo_r);
  assign stat.busy = (step_r != '0);
  assign stat.done = done_r;

endmodule

`default_nettype wire

FILE: design/box_filter_rate_decimator_core.sv
// Box-filter fractional rate decimator, stereo, with iterative divider.
// Usage:
//   Input channel in_valid/in_ready carries one stereo sample. While enable
//   is 0 every request is taken and dropped. Otherwise both channels are
//   added to running sums and a phase accumulator grows by output_rate; when
//   it reaches input_rate one averaged sample is produced.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes input_rate
//   (0), output_rate (1) and enable (2); it is always ready and is meant to
//   be written while the block is idle. Writes do not clear the sums.
//   Output channel out_valid/out_ready carries the two averages, the slot in
//   a group of GROUP_SIZE and a last-of-group flag, held in an output
//   register until taken.
// Timing: a sample that produces no output is taken in ST_IDLE and the block
//   stays ready for the next. A sample that does runs the shared divider,
//   which resolves one quotient bit a cycle for left then right, and in_ready
//   stays low until the result is pushed. If the output register is still full the
//   block waits in its final step until out_ready frees it.
// Reset: synchronous, active low; registers return to their documented
//   values, sums, count, phase and slot clear, output goes invalid.
// Depends on bfrd_pkg and bfrd_divider.
`default_nettype none

module box_filter_rate_decimator_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int GROUP_SIZE  = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input request
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]     in_right_in,
  // result request
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_left_avg,
  output logic signed [SAMPLE_BITS-1:0]     out_right_avg,
  output logic [1:0]                        out_group_slot,
  output logic                              out_group_last,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfrd_pkg::RATE_W-1:0]       cfg_data
);
  import bfrd_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + 19;
  localparam int EXT_W  = SUM_W - SAMPLE_BITS;
  localparam int SLOT_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

  // configuration registers
  logic [RATE_W-1:0] input_rate_r;
  logic [RATE_W-1:0] output_rate_r;
  logic              enable_r;

  // filter state
  logic [RATE_W-1:0]       rate_accum_r;
  logic signed [SUM_W-1:0] left_sum_r;
  logic signed [SUM_W-1:0] right_sum_r;
  logic [CNT_W-1:0]        count_r;
  logic [SLOT_W-1:0]       slot_r;

  bfrd_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] left_q_r;
  logic signed [SAMPLE_BITS-1:0] right_q_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r;
  logic signed [SAMPLE_BITS-1:0] out_right_r;
  logic [SLOT_W-1:0]             out_slot_r;
  logic                          out_last_r;

  // sequencer outputs
  logic div_start;
  logic latch_left;
  logic latch_right;
  logic push;

  logic                          in_fire;
  logic                          take;
  logic [RATE_W-1:0]             thr;
  logic [RATE_W:0]               acc;
  logic [RATE_W+1:0]             thr2;
  logic                          emit;
  logic                          sat;
  logic [RATE_W:0]               acc_sub;
  logic [RATE_W-1:0]             accum_nxt;
  logic                          slot_last;
  logic [SLOT_W+1:0]             slot_ext;

  logic signed [SUM_W-1:0]       div_dividend;
  logic signed [SAMPLE_BITS-1:0] div_q;
  bfrd_div_stat_t                div_st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_rate_r  <= INPUT_RATE_RST;
      output_rate_r <= OUTPUT_RATE_RST;
      enable_r      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INPUT_RATE:  input_rate_r  <= cfg_data;
        CFG_OUTPUT_RATE: output_rate_r <= cfg_data;
        CFG_ENABLE:      enable_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Phase accumulator: a zero threshold acts as one.
  assign in_fire = in_valid && in_ready;
  assign take    = in_fire && enable_r;
  assign thr     = (input_rate_r == '0) ? RATE_W'(1) : input_rate_r;
  assign acc     = {1'b0, rate_accum_r} + {1'b0, output_rate_r};
  assign thr2    = {1'b0, thr, 1'b0};
  assign emit    = (acc >= {1'b0, thr});
  assign sat     = ({1'b0, acc} >= thr2);
  assign acc_sub = acc - {1'b0, thr};
  always_comb begin
    if (!emit) begin
      accum_nxt = acc[RATE_W-1:0];
    end else if (sat) begin
      accum_nxt = thr - 1'b1;
    end else begin
      accum_nxt = acc_sub[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_accum_r <= '0;
    end else if (take) begin
      rate_accum_r <= accum_nxt;
    end
  end

  // Hold the sums once the count is full; clear them when the result is pushed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_sum_r  <= '0;
      right_sum_r <= '0;
      count_r     <= '0;
    end else if (push) begin
      left_sum_r  <= '0;
      right_sum_r <= '0;
      count_r     <= '0;
    end else if (take && (count_r != CNT_MAX)) begin
      left_sum_r  <= left_sum_r + {{EXT_W{in_left_in[SAMPLE_BITS-1]}}, in_left_in};
      right_sum_r <= right_sum_r + {{EXT_W{in_right_in[SAMPLE_BITS-1]}}, in_right_in};
      count_r     <= count_r + 1'b1;
    end
  end

  assign slot_last = (slot_r == SLOT_W'(GROUP_SIZE - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (push) begin
      slot_r <= slot_last ? '0 : slot_r + 1'b1;
    end
  end

  assign div_dividend = (state_r == ST_RIGHT_GO) ? right_sum_r : left_sum_r;

  bfrd_divider #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_W      (SUM_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (count_r),
    .quotient(div_q),
    .stat    (div_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    div_start   = 1'b0;
    latch_left  = 1'b0;
    latch_right = 1'b0;
    push        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (take && emit) begin
          state_nxt = ST_LEFT_GO;
        end
      end
      ST_LEFT_GO: begin
        div_start = 1'b1;
        state_nxt = ST_LEFT_WAIT;
      end
      ST_LEFT_WAIT: begin
        if (div_st.done) begin
          latch_left = 1'b1;
          state_nxt  = ST_RIGHT_GO;
        end
      end
      ST_RIGHT_GO: begin
        div_start = 1'b1;
        state_nxt = ST_RIGHT_WAIT;
      end
      ST_RIGHT_WAIT: begin
        if (div_st.done) begin
          latch_right = 1'b1;
          state_nxt   = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (latch_left) begin
      left_q_r <= div_q;
    end
    if (latch_right) begin
      right_q_r <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_left_r  <= left_q_r;
      out_right_r <= right_q_r;
      out_slot_r  <= slot_r;
      out_last_r  <= slot_last;
    end
  end

  assign slot_ext       = {2'b00, out_slot_r};
  assign out_valid      = out_valid_r;
  assign out_left_avg   = out_left_r;
  assign out_right_avg  = out_right_r;
  assign out_group_slot = slot_ext[1:0];
  assign out_group_last = out_last_r;

  // After an emitted request the phase must sit below the threshold.
  a_phase_below_thr: assert property (@(posedge clk) disable iff (!rst_n)
    (take && emit) |=> (rate_accum_r < $past(thr)))
    else $error("phase accumulator left at or above threshold");

  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

  a_nonzero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEFT_GO || state_r == ST_RIGHT_GO) |-> (count_r != '0))
    else $error("division started with zero count");

  a_no_input_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> !in_ready)
    else $error("input taken while divider busy");

endmodule

`default_nettype wire

FILE: verif/bfrd_avg_checker.sv
// Checker for the box-filter rate decimator: mirrors the register writes, predicts
// every averaged sample from the accepted requests and compares the results.
// Depends on bfrd_pkg for the register codes and widths.
module bfrd_avg_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int GROUP_SIZE  = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]       in_right_in,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [SAMPLE_BITS-1:0]       out_left_avg,
  input  logic signed [SAMPLE_BITS-1:0]       out_right_avg,
  input  logic [1:0]                          out_group_slot,
  input  logic                                out_group_last,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [bfrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfrd_pkg::RATE_W-1:0]         cfg_data,
  output int                                  fail_count,
  output int                                  avg_backlog,
  output int                                  avg_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import bfrd_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [1:0]                    slot;
    logic                          last;
  } avg_sample_t;

  // mirrored registers
  logic [RATE_W-1:0] thr_rate;
  logic [RATE_W-1:0] step_rate;
  logic              run_en;

  // mirrored datapath state
  logic [RATE_W-1:0] phase_acc;
  longint            left_acc;
  longint            right_acc;
  logic [CNT_W-1:0]  sample_cnt;
  int                grp_slot;

  avg_sample_t pending_avgs[$];
  avg_sample_t want;
  int          mismatches = 0;
  int          matched = 0;

  assign fail_count  = mismatches;
  assign avg_checked = matched;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Accumulate one stereo sample and queue an average when the phase wraps.
  task automatic decimate_sample(input logic signed [SAMPLE_BITS-1:0] l,
                                 input logic signed [SAMPLE_BITS-1:0] r);
    logic [RATE_W:0] thr;
    logic [RATE_W:0] acc;
    avg_sample_t     avg;
    if (!run_en) return;
    if (sample_cnt != CNT_MAX) begin
      left_acc  += l;
      right_acc += r;
      sample_cnt++;
    end
    thr = (thr_rate == '0) ? (RATE_W+1)'(1) : {1'b0, thr_rate};
    acc = {1'b0, phase_acc} + {1'b0, step_rate};
    if (acc < thr) begin
      phase_acc = acc[RATE_W-1:0];
      return;
    end
    acc -= thr;
    // clamp when the output rate outruns the input rate
    if (acc >= thr) acc = thr - 1'b1;
    phase_acc = acc[RATE_W-1:0];
    avg.left  = SAMPLE_BITS'(left_acc / longint'(sample_cnt));
    avg.right = SAMPLE_BITS'(right_acc / longint'(sample_cnt));
    avg.slot  = 2'(grp_slot);
    avg.last  = (grp_slot == GROUP_SIZE - 1);
    grp_slot  = (grp_slot >= GROUP_SIZE - 1) ? 0 : grp_slot + 1;
    left_acc   = 0;
    right_acc  = 0;
    sample_cnt = '0;
    pending_avgs.push_back(avg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thr_rate   = INPUT_RATE_RST;
      step_rate  = OUTPUT_RATE_RST;
      run_en     = 1'b0;
      phase_acc  = '0;
      left_acc   = 0;
      right_acc  = 0;
      sample_cnt = '0;
      grp_slot   = 0;
      pending_avgs.delete();
    end else begin
      // results first: a result can never belong to a request taken on the same edge
      if (out_valid && out_ready) begin
        if (pending_avgs.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d/%0d slot %0d",
                                    out_left_avg, out_right_avg, out_group_slot));
        end else begin
          want = pending_avgs.pop_front();
          matched++;
          if (out_left_avg !== want.left)
            report_mismatch($sformatf("left_avg %0d, wanted %0d", out_left_avg, want.left));
          if (out_right_avg !== want.right)
            report_mismatch($sformatf("right_avg %0d, wanted %0d",
                                      out_right_avg, want.right));
          if (out_group_slot !== want.slot)
            report_mismatch($sformatf("group_slot %0d, wanted %0d",
                                      out_group_slot, want.slot));
          if (out_group_last !== want.last)
            report_mismatch($sformatf("group_last %0b, wanted %0b",
                                      out_group_last, want.last));
        end
      end
      // a request on the same edge as a write still sees the old registers
      if (in_valid && in_ready) decimate_sample(in_left_in, in_right_in);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INPUT_RATE:  thr_rate  = cfg_data;
          CFG_OUTPUT_RATE: step_rate = cfg_data;
          CFG_ENABLE:      run_en    = cfg_data[0];
          default: ;
        endcase
      end
    end
    avg_backlog = pending_avgs.size();
  end

endmodule

FILE: verif/tb_box_filter_rate_decimator_core.sv
// Top of the box-filter rate decimator testbench: clock, reset, stimulus and verdict.
// Drives directed and random stereo requests under several rate settings.
// Depends on bfrd_pkg, box_filter_rate_decimator_core and bfrd_avg_checker.
module tb_box_filter_rate_decimator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bfrd_pkg::*;

  localparam int SAMPLE_BITS     = 16;
  localparam int GROUP_SIZE      = 4;
  localparam int SETTLE_CYCLES   = 2 * SAMPLE_BITS + 16;
  localparam int STALL_LIMIT     = 4000;
  localparam int ITEMS_PER_PHASE = 417;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [RATE_W-1:0]    RATE_MAX  = {RATE_W{1'b1}};

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_left_in = '0;
  logic signed [SAMPLE_BITS-1:0] in_right_in = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_left_avg;
  logic signed [SAMPLE_BITS-1:0] out_right_avg;
  logic [1:0]                    out_group_slot;
  logic                          out_group_last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [RATE_W-1:0]             cfg_data = '0;

  int fail_count;
  int avg_backlog;
  int avg_checked;

  int src_idle = 32;
  int dst_idle = 62;
  int samples_sent = 0;
  int writes_done = 0;
  int stall_cycles = 0;

  box_filter_rate_decimator_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .GROUP_SIZE  (GROUP_SIZE)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_left_in     (in_left_in),
    .in_right_in    (in_right_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left_avg   (out_left_avg),
    .out_right_avg  (out_right_avg),
    .out_group_slot (out_group_slot),
    .out_group_last (out_group_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  bfrd_avg_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .GROUP_SIZE  (GROUP_SIZE)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_left_in     (in_left_in),
    .in_right_in    (in_right_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left_avg   (out_left_avg),
    .out_right_avg  (out_right_avg),
    .out_group_slot (out_group_slot),
    .out_group_last (out_group_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .avg_backlog    (avg_backlog),
    .avg_checked    (avg_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= dst_idle);

  // end the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    case ($urandom_range(15))
      0:       s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1:       s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2:       s = '0;
      3:       s = '1;
      default: s = SAMPLE_BITS'($urandom);
    endcase
    return s;
  endfunction

  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] l,
                             input logic signed [SAMPLE_BITS-1:0] r);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_left_in  <= l;
    in_right_in <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    writes_done++;
  endtask

  task automatic program_rates(input logic [RATE_W-1:0] thr, input logic [RATE_W-1:0] step,
                               input logic [RATE_W-1:0] en_word, input bit poke_spare);
    write_reg(CFG_INPUT_RATE, thr);
    write_reg(CFG_OUTPUT_RATE, step);
    write_reg(CFG_ENABLE, en_word);
    if (poke_spare) write_reg(CFG_SPARE, RATE_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Hold off until every average is out and the divider has had time to finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (avg_backlog != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int               phase;
    int               seg_len;
    int               counted;
    logic [RATE_W-1:0] thr;
    logic [RATE_W-1:0] step;
    bit               live;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // disabled out of reset: drop these
    push_sample(16'sh7FFF, 16'sh7FFF);
    push_sample(16'sh8000, 16'sh8000);
    in_valid <= 1'b0;
    write_reg(CFG_ENABLE, 18'd1);
    cfg_valid <= 1'b0;
    push_sample(16'sh7FFF, 16'sh8000);
    push_sample(16'sh7FFF, 16'sh8000);
    push_sample(-16'sd1, 16'sd1);
    push_sample(16'sd0, 16'sd0);
    push_sample(16'sh8000, 16'sh7FFF);
    push_sample(16'sd1, -16'sd1);

    // zero threshold behaves as one
    settle();
    program_rates('0, 18'd1, 18'd1, 1'b0);
    push_sample(16'sh8000, 16'sh7FFF);
    push_sample(16'sh7FFF, 16'sh8000);

    // output rate far above input rate: phase clamps
    settle();
    program_rates(18'd5, RATE_MAX, 18'd1, 1'b1);
    push_sample(16'sd3, -16'sd3);
    push_sample(-16'sd7, 16'sd9);

    // zero step: accumulate without output, then flush with a fractional average
    settle();
    program_rates(RATE_MAX, '0, 18'd1, 1'b0);
    push_sample(-16'sd1, 16'sd1);
    push_sample(-16'sd1, 16'sd2);
    push_sample(16'sd0, 16'sd0);
    settle();
    program_rates(18'd1, 18'd1, 18'd1, 1'b0);
    push_sample(-16'sd1, 16'sd0);

    // enable taken from bit 0 only
    settle();
    program_rates(RATE_MAX, RATE_MAX, 18'h3FFFE, 1'b1);
    push_sample(16'sh1234, 16'sh4321);
    push_sample(16'sh5555, 16'shAAAA);
    settle();
    write_reg(CFG_ENABLE, 18'h2AAAB);
    cfg_valid <= 1'b0;
    push_sample(16'sh7FFF, 16'sh7FFF);

    for (phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 32 : (phase == 1) ? 62 : 0;
      dst_idle = (phase == 0) ? 62 : (phase == 1) ? 32 : 0;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        live = 1'b1;
        case ($urandom_range(9))
          0: begin
            thr  = RATE_MAX;
            step = RATE_MAX;
          end
          1: begin
            thr  = 18'd1;
            step = RATE_W'($urandom_range(1, RATE_MAX));
          end
          2: begin
            thr  = RATE_W'($urandom_range(1, RATE_MAX));
            step = RATE_W'(thr / $urandom_range(1, 8));
            if (step == '0) step = 18'd1;
          end
          3: begin
            thr  = RATE_W'($urandom_range(1, 1000));
            step = RATE_W'($urandom_range(thr + 1, RATE_MAX));
          end
          4: begin
            thr  = '0;
            step = RATE_W'($urandom_range(1, RATE_MAX));
          end
          5: begin
            thr  = RATE_W'($urandom_range(1, RATE_MAX));
            step = '0;
          end
          6: begin
            thr  = RATE_W'($urandom);
            step = RATE_W'($urandom);
            live = 1'b0;
          end
          default: begin
            thr  = RATE_W'($urandom_range(40000, 200000));
            step = RATE_W'($urandom_range(8000, thr));
          end
        endcase
        settle();
        program_rates(thr, step,
                      live ? (RATE_W'($urandom) | 18'd1) : (RATE_W'($urandom) & ~18'd1),
                      $urandom_range(3) == 0);
        if (live) begin
          seg_len = $urandom_range(60, 140);
          counted += seg_len;
        end else begin
          seg_len = 8;
        end
        repeat (seg_len) push_sample(rand_sample(), rand_sample());
      end
    end

    settle();
    $display("Sent %0d stereo samples and %0d register writes over directed and random rates.",
             samples_sent, writes_done);
    $display("Checked %0d averages across three idling mixes; %0d mismatches.",
             avg_checked, fail_count);
    if (fail_count == 0 && avg_backlog == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
